>>> design/windowed_event_statistics_defines.svh
// Assertion macros for the windowed event statistics block.
`ifndef WINDOWED_EVENT_STATISTICS_DEFINES_SVH
`define WINDOWED_EVENT_STATISTICS_DEFINES_SVH

`ifndef ASSERT_OFF
`define WES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define WES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WES_ASSERT(lbl, prop, msg)
`define WES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/wes_pkg.sv
`timescale 1ns / 1ps

package wes_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_FEAT    = 4;
  localparam int NUM_CHAN    = 5;

  localparam int ADDR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(STORE_DEPTH + 1);
  localparam int FEAT_W     = 32;
  localparam int STAMP_W    = 32;
  localparam int ENTRY_W    = STAMP_W + NUM_FEAT * FEAT_W;
  localparam int FEAT_IDX_W = 2;
  localparam int CH_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 32;

  localparam int S1_W   = FEAT_W + CNT_W;
  localparam int MAG_W  = S1_W - 1;
  localparam int S2_W   = 2 * FEAT_W + CNT_W;
  localparam int NUM_W  = 2 * MAG_W + 2;
  localparam int DIVD_W = NUM_W - 1;
  localparam int DEN_W  = 2 * CNT_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIVD_W);
  localparam int ROOT_W    = 64;
  localparam int ROOT_K_W  = 5;

  localparam longint SAT_MAX = 64'sh7fffffff;
  localparam longint SAT_MIN = -64'sh80000000;

  typedef enum logic [1:0] {
    STAT_SUM  = 2'd0,
    STAT_MEAN = 2'd1,
    STAT_VAR  = 2'd2,
    STAT_STD  = 2'd3
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STAT_FUNCTION  = 2'd0,
    CFG_WINDOW_ENABLE  = 2'd1,
    CFG_WINDOW_MS      = 2'd2,
    CFG_CHANNEL_ENABLE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic  start;
    stat_t func;
    logic  neg;
  } arith_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } arith_resp_t;

endpackage

>>> design/wes_ram.sv
`timescale 1ns / 1ps

module wes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/wes_arith.sv
`timescale 1ns / 1ps

module wes_arith (
  input  logic                         clk,
  input  logic                         rst,
  input  wes_pkg::arith_req_t          req,
  input  logic [wes_pkg::DIVD_W-1:0]   dividend,
  input  logic [wes_pkg::DEN_W-1:0]    divisor,
  output wes_pkg::arith_resp_t         resp,
  output logic [31:0]                  result
);

  import wes_pkg::*;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_DIV  = 4'b0010,
    A_SQRT = 4'b0100,
    A_DONE = 4'b1000
  } astate_t;

  astate_t               state;
  logic [DIVD_W-1:0]     dq;
  logic [DEN_W-1:0]      rem;
  logic [DEN_W-1:0]      den;
  logic [DIV_CNT_W-1:0]  cnt;
  stat_t                 func;
  logic                  neg;
  logic [ROOT_W-1:0]     sv;
  logic [ROOT_W-1:0]     sres;
  logic [ROOT_K_W-1:0]   sk;

  logic [DEN_W:0]        rem_sh;
  logic                  ge;
  logic [DIVD_W-1:0]     q_next;
  logic [ROOT_W-1:0]     sbit;
  logic [ROOT_W-1:0]     trial;
  logic                  take;
  logic [ROOT_W-1:0]     sres_next;

  always_comb begin
    rem_sh    = {rem, dq[DIVD_W-1]};
    ge        = rem_sh >= {1'b0, den};
    q_next    = {dq[DIVD_W-2:0], ge};
    sbit      = ROOT_W'(1) << {sk, 1'b0};
    trial     = sres + sbit;
    take      = sv >= trial;
    sres_next = take ? ((sres >> 1) + sbit) : (sres >> 1);
  end

  assign resp.done = (state == A_DONE);
  assign resp.busy = (state != A_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            dq    <= dividend;
            rem   <= '0;
            den   <= divisor;
            cnt   <= DIV_CNT_W'(DIVD_W - 1);
            func  <= req.func;
            neg   <= req.neg;
            state <= A_DIV;
          end
        end
        A_DIV: begin
          rem <= ge ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
          dq  <= q_next;
          cnt <= cnt - DIV_CNT_W'(1);
          if (cnt == '0) begin
            state <= A_DONE;
            unique case (func)
              STAT_MEAN: result <= neg ? (~q_next[31:0] + 32'd1) : q_next[31:0];
              STAT_VAR: begin
                result <= (q_next[DIVD_W-1:31] != '0) ? 32'(SAT_MAX) : q_next[31:0];
              end
              STAT_STD: begin
                if (q_next[DIVD_W-1:62] != '0) begin
                  result <= 32'(SAT_MAX);
                end else begin
                  sv    <= ROOT_W'(q_next[61:0]);
                  sres  <= '0;
                  sk    <= '1;
                  state <= A_SQRT;
                end
              end
              STAT_SUM: result <= q_next[31:0];
            endcase
          end
        end
        A_SQRT: begin
          if (take) begin
            sv <= sv - trial;
          end
          sres <= sres_next;
          sk   <= sk - ROOT_K_W'(1);
          if (sk == '0) begin
            result <= sres_next[31:0];
            state  <= A_DONE;
          end
        end
        A_DONE: state <= A_IDLE;
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

>>> design/windowed_event_statistics.sv
`timescale 1ns / 1ps
// Channel  | Handshake                 | Payload
// config   | cfg_write                 | cfg_index, cfg_data
// input    | in_valid / in_ready       | kind, tick_time_ms, amplitude, energy, power, rising_time
// output   | out_valid / out_ready     | channel, value, overflow, last
//
// An event item is one write to the store memory; a full store drops it and sets overflow.
// A tick drops entries older than the window (when enabled), checking the oldest in turn;
// then per enabled feature channel it walks the stored entries through the store's one
// read port, divides for mean, variance and std deviation (plus a square root), and emits.
// Reset is synchronous; the store needs no clearing pass, only entries counted live are read.
// Items are taken only while no tick is in work; a stalled output holds the next result.
`include "windowed_event_statistics_defines.svh"

module windowed_event_statistics (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [wes_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wes_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [31:0]                       tick_time_ms,
  input  logic signed [wes_pkg::FEAT_W-1:0] amplitude,
  input  logic signed [wes_pkg::FEAT_W-1:0] energy,
  input  logic signed [wes_pkg::FEAT_W-1:0] power,
  input  logic signed [wes_pkg::FEAT_W-1:0] rising_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wes_pkg::CH_W-1:0]          channel,
  output logic signed [31:0]                value,
  output logic                              overflow,
  output logic                              last
);

  import wes_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EV_RD  = 9'b000000010,
    S_EV_CHK = 9'b000000100,
    S_CHAN   = 9'b000001000,
    S_WALK   = 9'b000010000,
    S_PREP   = 9'b000100000,
    S_AGO    = 9'b001000000,
    S_ARITH  = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    OP_SQ_LL  = 3'd0,
    OP_SQ_LH  = 3'd1,
    OP_SQ_HH  = 3'd2,
    OP_NS_LO  = 3'd3,
    OP_NS_MID = 3'd4,
    OP_NS_HI  = 3'd5,
    OP_DONE   = 3'd6
  } prep_op_t;

  stat_t                stat_function;
  logic                 window_enable;
  logic [31:0]          window_ms;
  logic [NUM_CHAN-1:0]  channel_enable;

  state_t               state;
  logic [ADDR_W-1:0]    oldest;
  logic [CNT_W-1:0]     count;
  logic [31:0]          now;
  logic                 overflow_flag;
  logic [CH_W-1:0]      ch;
  logic [CNT_W-1:0]     issued;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 va, vb, vc;
  prep_op_t             step, pstep_b, pstep_c;
  logic signed [S1_W-1:0] s1;
  logic [S2_W-1:0]      s2;
  logic [31:0]          ma, mb;
  logic [63:0]          prod;
  logic [NUM_W-1:0]     num;
  logic [MAG_W-1:0]     s1mag;
  logic [2*CNT_W-1:0]   nn;
  logic [31:0]          res_value;
  logic [DIVD_W-1:0]    a_num;
  logic [DEN_W-1:0]     a_den;
  stat_t                a_func;
  logic                 a_neg;

  logic                 accept_in;
  logic [CNT_W:0]       wr_sum;
  logic [ADDR_W-1:0]    waddr;
  logic                 ram_we;
  logic                 ram_re;
  logic [ADDR_W-1:0]    raddr;
  logic [ENTRY_W-1:0]   wdata;
  logic [ENTRY_W-1:0]   rdata;
  logic [FEAT_IDX_W-1:0] fidx;
  logic [FEAT_W-1:0]    feat_sel;
  logic [FEAT_W-1:0]    feat_mag;
  logic                 walk_re;
  logic                 walk_done;
  logic                 prep_issue;
  logic                 prep_done;
  logic [MAG_W-1:0]     s1_mag;
  logic [31:0]          s1_sat;
  logic                 out_free;
  logic                 last_next;
  logic [31:0]          count_value;
  logic [31:0]          op_a, op_b;
  logic [NUM_W-1:0]     prod_ext;
  logic [NUM_W-1:0]     num_next;
  logic [STAMP_W-1:0]   age;
  logic                 full;

  arith_req_t           arith_req;
  arith_resp_t          arith_resp;
  logic [31:0]          arith_result;

  wes_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  wes_arith u_arith (
    .clk      (clk),
    .rst      (rst),
    .req      (arith_req),
    .dividend (a_num),
    .divisor  (a_den),
    .resp     (arith_resp),
    .result   (arith_result)
  );

  assign arith_req.start = (state == S_AGO);
  assign arith_req.func  = a_func;
  assign arith_req.neg   = a_neg;

  always_comb begin
    in_ready  = (state == S_IDLE);
    accept_in = in_valid && in_ready;
    full      = (count == CNT_W'(STORE_DEPTH));
    wr_sum    = (CNT_W+1)'(oldest) + (CNT_W+1)'(count);
    waddr     = (wr_sum >= (CNT_W+1)'(STORE_DEPTH)) ?
                ADDR_W'(wr_sum - (CNT_W+1)'(STORE_DEPTH)) : ADDR_W'(wr_sum);
    ram_we    = accept_in && !kind && !full;
    wdata     = {rising_time, power, energy, amplitude, now};
    walk_re   = (state == S_WALK) && (issued != count);
    ram_re    = walk_re || ((state == S_EV_RD) && (count != '0));
    raddr     = (state == S_WALK) ? rd_addr : oldest;
    age       = now - rdata[STAMP_W-1:0];
    fidx      = FEAT_IDX_W'(ch - CH_W'(1));
    feat_sel  = rdata[STAMP_W + FEAT_W*fidx +: FEAT_W];
    feat_mag  = feat_sel[FEAT_W-1] ? (~feat_sel + FEAT_W'(1)) : feat_sel;
    walk_done = (state == S_WALK) && (issued == count) && !va && !vb && !vc;
    prep_issue = (state == S_PREP) && (step != OP_DONE);
    prep_done  = (state == S_PREP) && (step == OP_DONE) && !vb && !vc;
    s1_mag    = s1[S1_W-1] ? MAG_W'(-s1) : MAG_W'(s1);
    if (s1 > S1_W'(SAT_MAX)) begin
      s1_sat = 32'(SAT_MAX);
    end else if (s1 < S1_W'(SAT_MIN)) begin
      s1_sat = 32'(SAT_MIN);
    end else begin
      s1_sat = 32'(s1);
    end
    out_free  = !out_valid || out_ready;
    last_next = ((channel_enable >> ch) >> 1) == '0;
    unique case (stat_function)
      STAT_SUM:  count_value = 32'(count) << FRAC_BITS;
      STAT_MEAN: count_value = 32'(1) << FRAC_BITS;
      STAT_VAR,
      STAT_STD:  count_value = '0;
    endcase
    unique case (step)
      OP_SQ_LL:  begin op_a = s1mag[31:0];            op_b = s1mag[31:0]; end
      OP_SQ_LH:  begin op_a = s1mag[31:0];            op_b = 32'(s1mag[MAG_W-1:32]); end
      OP_SQ_HH:  begin op_a = 32'(s1mag[MAG_W-1:32]); op_b = 32'(s1mag[MAG_W-1:32]); end
      OP_NS_LO:  begin op_a = 32'(count);             op_b = s2[31:0]; end
      OP_NS_MID: begin op_a = 32'(count);             op_b = s2[63:32]; end
      OP_NS_HI:  begin op_a = 32'(count);             op_b = 32'(s2[S2_W-1:64]); end
      OP_DONE:   begin op_a = '0;                     op_b = '0; end
      default:   begin op_a = '0;                     op_b = '0; end
    endcase
    prod_ext = NUM_W'(prod);
    unique case (pstep_c)
      OP_SQ_LL:  num_next = num - prod_ext;
      OP_SQ_LH:  num_next = num - (prod_ext << 33);
      OP_SQ_HH:  num_next = num - (prod_ext << 64);
      OP_NS_LO:  num_next = num + prod_ext;
      OP_NS_MID: num_next = num + (prod_ext << 32);
      OP_NS_HI:  num_next = num + (prod_ext << 64);
      OP_DONE:   num_next = num;
      default:   num_next = num;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat_function  <= STAT_SUM;
      window_enable  <= 1'b1;
      window_ms      <= 32'd10000;
      channel_enable <= '1;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STAT_FUNCTION:  stat_function  <= stat_t'(cfg_data[1:0]);
        CFG_WINDOW_ENABLE:  window_enable  <= cfg_data[0];
        CFG_WINDOW_MS:      window_ms      <= cfg_data[31:0];
        CFG_CHANNEL_ENABLE: channel_enable <= cfg_data[NUM_CHAN-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod    <= ma * mb;
    pstep_c <= pstep_b;
    if (walk_re) begin
      rd_addr <= (rd_addr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : rd_addr + ADDR_W'(1);
      issued  <= issued + CNT_W'(1);
    end
    if (va) begin
      s1 <= s1 + S1_W'(signed'(feat_sel));
      ma <= feat_mag;
      mb <= feat_mag;
    end
    if (prep_issue) begin
      ma      <= op_a;
      mb      <= op_b;
      pstep_b <= step;
      step    <= prep_op_t'(step + 3'd1);
    end
    if (vc) begin
      if (state == S_WALK) begin
        s2 <= s2 + S2_W'(prod);
      end else begin
        num <= num_next;
      end
    end
    if (state == S_CHAN) begin
      s1      <= '0;
      s2      <= '0;
      issued  <= '0;
      rd_addr <= oldest;
      if (ch == '0) begin
        res_value <= count_value;
      end else begin
        res_value <= '0;
      end
    end
    if (walk_done) begin
      nn    <= (2*CNT_W)'(count) * (2*CNT_W)'(count);
      s1mag <= s1_mag;
      num   <= '0;
      step  <= OP_SQ_LL;
      res_value <= s1_sat;
      a_num  <= DIVD_W'(s1_mag);
      a_den  <= DEN_W'(count);
      a_func <= STAT_MEAN;
      a_neg  <= s1[S1_W-1];
    end
    if (prep_done) begin
      a_num  <= num[DIVD_W-1:0];
      a_den  <= (stat_function == STAT_VAR) ? (DEN_W'(nn) << FRAC_BITS) : DEN_W'(nn);
      a_func <= stat_function;
      a_neg  <= 1'b0;
    end
    if ((state == S_ARITH) && arith_resp.done) begin
      res_value <= arith_result;
    end
    if ((state == S_EMIT) && out_free) begin
      channel  <= ch;
      value    <= res_value;
      overflow <= overflow_flag;
      last     <= last_next;
    end
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= walk_re;
      vb <= va || prep_issue;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      oldest        <= '0;
      count         <= '0;
      now           <= '0;
      overflow_flag <= 1'b0;
      ch            <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept_in) begin
            if (!kind) begin
              if (full) begin
                overflow_flag <= 1'b1;
              end else begin
                count <= count + CNT_W'(1);
              end
            end else begin
              now <= tick_time_ms;
              ch  <= '0;
              state <= window_enable ? S_EV_RD : S_CHAN;
            end
          end
        end
        S_EV_RD: state <= (count != '0) ? S_EV_CHK : S_CHAN;
        S_EV_CHK: begin
          if (age > window_ms) begin
            oldest <= (oldest == ADDR_W'(STORE_DEPTH - 1)) ? '0 : oldest + ADDR_W'(1);
            count  <= count - CNT_W'(1);
            state  <= S_EV_RD;
          end else begin
            state <= S_CHAN;
          end
        end
        S_CHAN: begin
          if (ch == CH_W'(NUM_CHAN)) begin
            state <= S_IDLE;
          end else if (!channel_enable[ch]) begin
            ch <= ch + CH_W'(1);
          end else if ((ch == '0) || (count == '0)) begin
            state <= S_EMIT;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            unique case (stat_function)
              STAT_SUM:  state <= S_EMIT;
              STAT_MEAN: state <= S_AGO;
              STAT_VAR,
              STAT_STD:  state <= S_PREP;
            endcase
          end
        end
        S_PREP: begin
          if (prep_done) begin
            state <= S_AGO;
          end
        end
        S_AGO: state <= S_ARITH;
        S_ARITH: begin
          if (arith_resp.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            ch        <= ch + CH_W'(1);
            state     <= S_CHAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `WES_ASSERT(a_ovf_sticky, !$fell(overflow_flag), "overflow flag cleared")
  `WES_ASSERT_NEXT(a_full_hold, accept_in && !kind && full, full && overflow_flag, "full store changed by event")
  `WES_ASSERT(a_done_state, !arith_resp.done || (state == S_ARITH), "arith result outside wait")
  `WES_ASSERT(a_start_idle, !arith_req.start || !arith_resp.busy, "arith started while busy")

endmodule

>>> bench/tb_windowed_event_statistics.sv
`timescale 1ns / 1ps

module tb_windowed_event_statistics;
  import wes_pkg::*;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_TICK  = 1'b1;
  localparam int   CH_COUNT   = 0;
  localparam int   SETTLE_CYCLES = 1500;

  typedef struct {
    logic [CH_W-1:0] channel;
    logic [31:0]     value;
    logic            overflow;
    logic            last;
  } stat_result_t;

  class stats_scoreboard;
    logic [31:0]  stamp [STORE_DEPTH];
    logic [31:0]  feat [STORE_DEPTH][NUM_FEAT];
    int unsigned  head;
    int unsigned  count;
    logic [31:0]  now_ms;
    logic         ovf;
    stat_t        func;
    logic         win_en;
    logic [31:0]  win_ms;
    logic [4:0]   ch_en;
    stat_result_t pending [$];
    int           errors;

    function new();
      head = 0;
      count = 0;
      now_ms = 0;
      ovf = 0;
      func = STAT_SUM;
      win_en = 1;
      win_ms = 10000;
      ch_en = 5'h1f;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_STAT_FUNCTION:  func = stat_t'(data[1:0]);
        CFG_WINDOW_ENABLE:  win_en = data[0];
        CFG_WINDOW_MS:      win_ms = data;
        CFG_CHANNEL_ENABLE: ch_en = data[4:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
      return res;
    endfunction

    function logic [31:0] feature_value(int f);
      longint        s1;
      logic [127:0]  s2;
      logic [127:0]  num;
      logic [127:0]  q;
      longint        x;
      logic [63:0]   mag;
      logic [63:0]   root;
      longint        n;
      if (count == 0) return 0;
      s1 = 0;
      s2 = 0;
      n = count;
      for (int i = 0; i < count; i++) begin
        x = longint'(signed'(feat[(head + i) % STORE_DEPTH][f]));
        s1 += x;
        mag = (x < 0) ? -x : x;
        s2 += 128'(mag) * 128'(mag);
      end
      case (func)
        STAT_SUM: begin
          if (s1 > SAT_MAX) return SAT_MAX[31:0];
          if (s1 < SAT_MIN) return SAT_MIN[31:0];
          return s1[31:0];
        end
        STAT_MEAN: begin
          x = s1 / n;
          return x[31:0];
        end
        default: begin
          mag = (s1 < 0) ? -s1 : s1;
          num = s2 * 128'(n) - 128'(mag) * 128'(mag);
          if (func == STAT_VAR) begin
            q = num / ((128'(n) * 128'(n)) << FRAC_BITS);
            if (q > 128'(SAT_MAX)) return SAT_MAX[31:0];
            return q[31:0];
          end
          q = num / (128'(n) * 128'(n));
          if (q >= (128'd1 << 62)) return SAT_MAX[31:0];
          root = int_sqrt(q[63:0]);
          if (root > 64'(SAT_MAX)) return SAT_MAX[31:0];
          return root[31:0];
        end
      endcase
    endfunction

    function void note_input(logic k, logic [31:0] t, logic [31:0] a, logic [31:0] e,
                             logic [31:0] p, logic [31:0] r);
      int unsigned  idx;
      int           nres;
      stat_result_t res;
      if (k == KIND_EVENT) begin
        if (count >= STORE_DEPTH) begin
          ovf = 1;
          return;
        end
        idx = (head + count) % STORE_DEPTH;
        stamp[idx] = now_ms;
        feat[idx][0] = a;
        feat[idx][1] = e;
        feat[idx][2] = p;
        feat[idx][3] = r;
        count++;
        return;
      end
      now_ms = t;
      if (win_en) begin
        while (count > 0 && (now_ms - stamp[head]) > win_ms) begin
          head = (head + 1) % STORE_DEPTH;
          count--;
        end
      end
      nres = 0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        if (!ch_en[c]) continue;
        res.channel = c[CH_W-1:0];
        if (c == CH_COUNT) begin
          case (func)
            STAT_SUM:  res.value = 32'(count) << FRAC_BITS;
            STAT_MEAN: res.value = 32'd1 << FRAC_BITS;
            default:   res.value = 0;
          endcase
        end else begin
          res.value = feature_value(c - 1);
        end
        res.overflow = ovf;
        res.last = 0;
        pending = {pending, res};
        nres++;
      end
      if (nres > 0) pending[pending.size() - 1].last = 1;
    endfunction

    function void check_result(stat_result_t got);
      stat_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result: channel %0d value %h", got.channel, got.value);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.channel !== exp_r.channel) begin
        $error("channel: expected %0d, actual %0d", exp_r.channel, got.channel);
        errors++;
      end
      if (got.value !== exp_r.value) begin
        $error("value: expected %h, actual %h", exp_r.value, got.value);
        errors++;
      end
      if (got.overflow !== exp_r.overflow) begin
        $error("overflow: expected %0b, actual %0b", exp_r.overflow, got.overflow);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0b, actual %0b", exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 0;
  logic                    rst = 1;
  logic                    cfg_write = 0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 0;
  logic                    in_ready;
  logic                    kind = 0;
  logic [31:0]             tick_time_ms = '0;
  logic signed [FEAT_W-1:0] amplitude = '0;
  logic signed [FEAT_W-1:0] energy = '0;
  logic signed [FEAT_W-1:0] power = '0;
  logic signed [FEAT_W-1:0] rising_time = '0;
  logic                    out_valid;
  logic                    out_ready = 0;
  logic [CH_W-1:0]         channel;
  logic signed [31:0]      value;
  logic                    overflow;
  logic                    last;

  stats_scoreboard stats_sb = new();
  logic [31:0]     clock_ms = 0;
  int              stall_left = 0;
  bit              no_idle = 0;
  int              items_sent = 0;

  windowed_event_statistics i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .tick_time_ms(tick_time_ms),
    .amplitude(amplitude), .energy(energy), .power(power), .rising_time(rising_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .channel(channel), .value(value), .overflow(overflow), .last(last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function int pick_gap();
    if (no_idle) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      9:          return $urandom_range(10, 40);
      default:    return $urandom_range(1, 3);
    endcase
  endfunction

  always @(posedge clk) begin
    stat_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.channel = channel;
      got.value = value;
      got.overflow = overflow;
      got.last = last;
      stats_sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else begin
      stall_left <= pick_gap();
      out_ready <= 1;
    end
  end

  task automatic write_regs(logic [1:0] func, logic wen, logic [31:0] wms, logic [4:0] chen);
    logic [31:0] vals [4];
    vals[0] = {30'h0, func};
    vals[1] = {31'h0, wen};
    vals[2] = wms;
    vals[3] = {27'h0, chen};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      stats_sb.set_reg(cfg_idx_t'(i), vals[i]);
      @(posedge clk);
    end
    cfg_write <= 0;
  endtask

  task automatic send_item(logic k, logic [31:0] t, logic [31:0] a, logic [31:0] e,
                           logic [31:0] p, logic [31:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    tick_time_ms <= t;
    amplitude <= a;
    energy <= e;
    power <= p;
    rising_time <= r;
    do @(posedge clk); while (!in_ready);
    stats_sb.note_input(k, t, a, e, p, r);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (stats_sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function logic [31:0] rand_feature();
    case ($urandom_range(0, 9))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2, 3, 4: return $urandom_range(0, 32'h7ffff) - 32'h40000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_event();
    send_item(KIND_EVENT, $urandom, rand_feature(), rand_feature(), rand_feature(),
              rand_feature());
  endtask

  task automatic send_tick();
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 400);
    send_item(KIND_TICK, clock_ms, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic random_phase(int n);
    int tick_pct;
    tick_pct = $urandom_range(10, 35);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      else send_event();
    end
    send_tick();
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_regs(STAT_SUM, 1, 10000, 5'h1f);
    send_item(KIND_TICK, 0, 0, 0, 0, 0);
    send_item(KIND_EVENT, 0, 32'h7fffffff, 32'h80000000, 0, 32'hffffffff);
    send_item(KIND_EVENT, 0, 32'h7fffffff, 32'h80000000, 32'h00010000, 32'hffffffff);
    send_item(KIND_TICK, 0, 0, 0, 0, 0);
    drain();
    write_regs(STAT_MEAN, 1, 10000, 5'h1f);
    send_item(KIND_TICK, 5, 0, 0, 0, 0);
    send_item(KIND_EVENT, 0, 32'h80000000, 32'h7fffffff, 32'hfffeffff, 1);
    send_item(KIND_TICK, 10000, 0, 0, 0, 0);
    send_item(KIND_TICK, 10006, 0, 0, 0, 0);
    drain();
    write_regs(STAT_VAR, 1, 32'hffffffff, 5'h1f);
    send_item(KIND_EVENT, 0, 32'h7fffffff, 32'h80000000, 5, 32'h12345678);
    send_item(KIND_EVENT, 0, 32'h80000000, 32'h7fffffff, 5, 32'hedcba987);
    send_item(KIND_TICK, 32'hffffffff, 0, 0, 0, 0);
    drain();
    write_regs(STAT_STD, 1, 32'hffffffff, 5'h1f);
    send_item(KIND_TICK, 0, 0, 0, 0, 0);
    send_item(KIND_EVENT, 0, 32'h00020000, 32'h80000000, 7, 32'h7fffffff);
    send_item(KIND_TICK, 3, 0, 0, 0, 0);
    drain();
    write_regs(STAT_STD, 1, 0, 5'h00);
    send_item(KIND_TICK, 100, 0, 0, 0, 0);
    send_item(KIND_TICK, 100, 0, 0, 0, 0);
    drain();
    write_regs(STAT_MEAN, 1, 0, 5'h01);
    send_item(KIND_TICK, 200, 0, 0, 0, 0);
    drain();

    // Fill the store past its depth so events get dropped.
    write_regs(STAT_SUM, 0, 0, 5'h1f);
    for (int i = 0; i < STORE_DEPTH + 2; i++) send_event();
    send_tick();
    drain();

    write_regs(STAT_VAR, 0, 0, 5'h1f);
    send_tick();
    drain();

    clock_ms = 0;
    write_regs(STAT_MEAN, 1, 0, 5'h1f);
    send_tick();
    drain();

    while (items_sent < 225) begin
      write_regs(2'($urandom_range(0, 3)), 1'($urandom_range(0, 3) != 0),
                 ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1500),
                 ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'h1f);
      random_phase($urandom_range(15, 40));
    end

    write_regs(STAT_STD, 1, 32'hffffffff, 5'h1f);
    random_phase(20);

    if (stats_sb.errors == 0 && stats_sb.pending.size() == 0) begin
      $display("PASS windowed_event_statistics");
    end else begin
      $display("FAIL windowed_event_statistics");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL windowed_event_statistics");
    $finish;
  end

endmodule
